// ===== design/lsmt_pkg.sv =====
`default_nettype none

package lsmt_pkg;

  // Display modes in the standard status encoding
  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_INT_EN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LYC_INT_EN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE  = 2'd2;

  localparam int DOT_W    = 10;
  localparam int LINE_W   = 8;
  localparam int CYCLES_W = 6;

  localparam logic [DOT_W-1:0] DOTS_OAM      = 10'd80;
  localparam logic [DOT_W-1:0] DOTS_TRANSFER = 10'd172;
  localparam logic [DOT_W-1:0] DOTS_HBLANK   = 10'd204;
  localparam logic [DOT_W-1:0] DOTS_LINE     = 10'd456;

  localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

  typedef struct packed {
    logic              hblank_int_enable;
    logic              lyc_int_enable;
    logic [LINE_W-1:0] line_compare;
  } lsmt_cfg_t;

  typedef struct packed {
    logic [DOT_W-1:0]  dot_count;
    logic [LINE_W-1:0] line_number;
    mode_t             current_mode;
    logic              match_flag;
  } lsmt_state_t;

  typedef struct packed {
    logic vblank_irq;
    logic stat_irq;
    logic render_line;
    logic frame_done;
  } lsmt_pulse_t;

endpackage

`default_nettype wire

// ===== design/lsmt_cfg.sv =====
`default_nettype none

module lsmt_cfg
  import lsmt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [LINE_W-1:0]      cfg_data,
  output lsmt_cfg_t                   cfg
);

  lsmt_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HBLANK_INT_EN: regs.hblank_int_enable <= cfg_data[0];
        REG_LYC_INT_EN:    regs.lyc_int_enable    <= cfg_data[0];
        REG_LINE_COMPARE:  regs.line_compare      <= cfg_data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/lsmt_step.sv =====
`default_nettype none

module lsmt_step
  import lsmt_pkg::*;
(
  input  wire lsmt_state_t          state,
  input  wire lsmt_cfg_t            cfg,
  input  wire logic [CYCLES_W-1:0]  cpu_cycles,
  output lsmt_state_t               state_next,
  output lsmt_pulse_t               pulse
);

  logic [DOT_W-1:0]  dot_sum;
  logic [LINE_W-1:0] line_inc;
  logic              hit;

  assign dot_sum  = state.dot_count + {{(DOT_W-CYCLES_W){1'b0}}, cpu_cycles};
  assign line_inc = state.line_number + 8'd1;
  assign hit      = (state.line_number == cfg.line_compare);

  always_comb begin
    state_next           = state;
    state_next.dot_count = dot_sum;
    pulse                = '0;
    case (state.current_mode)
      MODE_HBLANK: begin
        if (dot_sum >= DOTS_HBLANK) begin
          state_next.line_number = line_inc;
          state_next.dot_count   = dot_sum - DOTS_HBLANK;
          if (line_inc == FIRST_VBLANK_LINE) begin
            state_next.current_mode = MODE_VBLANK;
            pulse.vblank_irq        = 1'b1;
            pulse.frame_done        = 1'b1;
          end else begin
            state_next.current_mode = MODE_OAM;
          end
        end
      end
      MODE_VBLANK: begin
        if (dot_sum >= DOTS_LINE) begin
          state_next.dot_count = dot_sum - DOTS_LINE;
          if (line_inc > LAST_LINE) begin
            state_next.line_number  = '0;
            state_next.current_mode = MODE_OAM;
          end else begin
            state_next.line_number = line_inc;
          end
        end
      end
      MODE_OAM: begin
        if (dot_sum >= DOTS_OAM) begin
          state_next.dot_count    = dot_sum - DOTS_OAM;
          state_next.current_mode = MODE_TRANSFER;
        end
      end
      MODE_TRANSFER: begin
        if (dot_sum >= DOTS_TRANSFER) begin
          state_next.dot_count    = dot_sum - DOTS_TRANSFER;
          state_next.current_mode = MODE_HBLANK;
          state_next.match_flag   = hit;
          pulse.render_line       = 1'b1;
          pulse.stat_irq          = cfg.hblank_int_enable || (cfg.lyc_int_enable && hit);
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lcd_scanline_mode_timing.sv =====
`default_nettype none

// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------------------
// input     | in_valid / in_stall (we)      | cpu_cycles
// result    | out_valid / out_stall (sink)  | mode, scanline, coincidence, vblank_irq,
//           |                               | stat_irq, render_line, frame_done
// config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per clock sustained while out_stall stays low; each item passes through
// the input register and then the result register.
// The input register feeds one add, one threshold compare and one subtract; the
// sequencer state and the result register update together at the same edge.
// Reset (rst, synchronous) returns line 0, hblank mode, dot count 0, flags clear.
// A stall on the result side holds the output register; the input register
// still drains into it as soon as it empties, so in_stall rises only when both
// stages are full.

module lcd_scanline_mode_timing
  import lsmt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CYCLES_W-1:0]    cpu_cycles,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  mode,
  output logic [LINE_W-1:0]           scanline,
  output logic                        coincidence,
  output logic                        vblank_irq,
  output logic                        stat_irq,
  output logic                        render_line,
  output logic                        frame_done,
  // configuration channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [LINE_W-1:0]      cfg_data
);

  lsmt_cfg_t   cfg;
  lsmt_state_t state;
  lsmt_state_t state_next;
  lsmt_pulse_t pulse;
  lsmt_pulse_t out_pulse;

  // input register
  logic                in_full;
  logic [CYCLES_W-1:0] in_cycles;

  // result register
  mode_t             out_mode;
  logic [LINE_W-1:0] out_line;
  logic              out_match;

  logic advance;
  logic in_take;

  // Advance the held item into the result register whenever that register
  // is empty or its current result is being transferred this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  lsmt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsmt_step u_step (
    .state      (state),
    .cfg        (cfg),
    .cpu_cycles (in_cycles),
    .state_next (state_next),
    .pulse      (pulse)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cycles <= cpu_cycles;
    end
  end

  // sequencer state: commit only when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.dot_count    <= '0;
      state.line_number  <= '0;
      state.current_mode <= MODE_HBLANK;
      state.match_flag   <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode  <= state_next.current_mode;
      out_line  <= state_next.line_number;
      out_match <= state_next.match_flag;
      out_pulse <= pulse;
    end
  end

  assign mode        = out_mode;
  assign scanline    = out_line;
  assign coincidence = out_match;
  assign vblank_irq  = out_pulse.vblank_irq;
  assign stat_irq    = out_pulse.stat_irq;
  assign render_line = out_pulse.render_line;
  assign frame_done  = out_pulse.frame_done;

endmodule

`default_nettype wire

// ===== design/lsmt_checker.sv =====
`default_nettype none

module lsmt_checker
  import lsmt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        mode,
  input wire logic [LINE_W-1:0] scanline,
  input wire logic              vblank_irq,
  input wire logic              stat_irq,
  input wire logic              render_line,
  input wire logic              frame_done
);

  // status interrupt only at the end of pixel transfer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stat_irq |-> render_line)
    else $error("stat_irq without transfer end");

  // a transfer end always lands in hblank
  assert property (@(posedge clk) disable iff (rst)
    out_valid && render_line |-> mode == MODE_HBLANK)
    else $error("render_line outside hblank entry");

  // vblank entry happens on the first vblank line together with frame-done
  assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |->
      frame_done && mode == MODE_VBLANK && scanline == FIRST_VBLANK_LINE)
    else $error("vblank_irq inconsistent with frame state");

  // line counter stays within the frame
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scanline <= LAST_LINE)
    else $error("scanline out of range");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode) && $stable(scanline))
    else $error("stalled result changed");

endmodule

bind lcd_scanline_mode_timing lsmt_checker u_lsmt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .mode        (mode),
  .scanline    (scanline),
  .vblank_irq  (vblank_irq),
  .stat_irq    (stat_irq),
  .render_line (render_line),
  .frame_done  (frame_done)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  import lsmt_pkg::*;

  // One result as it leaves the block
  typedef struct packed {
    mode_t             mode;
    logic [LINE_W-1:0] scanline;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_line;
    logic              frame_done;
  } scan_result_t;

  // Mode sequencer model plus the queue of results still owed by the block
  class line_timing_scoreboard;
    logic              hblank_int_en;
    logic              lyc_int_en;
    logic [LINE_W-1:0] line_cmp;
    logic [DOT_W-1:0]  dots;
    logic [LINE_W-1:0] line;
    mode_t             cur_mode;
    logic              match;
    scan_result_t      owed_q[$];
    int                mismatches;
    int                inputs_seen;
    int                results_seen;
    int                transfer_ends;
    int                vblank_entries;
    int                frame_wraps;
    int                stat_pulses;
    int                line_hits;

    function new();
      hblank_int_en  = 1'b0;
      lyc_int_en     = 1'b0;
      line_cmp       = '0;
      dots           = '0;
      line           = '0;
      cur_mode       = MODE_HBLANK;
      match          = 1'b0;
      mismatches     = 0;
      inputs_seen    = 0;
      results_seen   = 0;
      transfer_ends  = 0;
      vblank_entries = 0;
      frame_wraps    = 0;
      stat_pulses    = 0;
      line_hits      = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [LINE_W-1:0] data);
      case (idx)
        REG_HBLANK_INT_EN: hblank_int_en = data[0];
        REG_LYC_INT_EN:    lyc_int_en    = data[0];
        REG_LINE_COMPARE:  line_cmp      = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic [CYCLES_W-1:0] cycles);
      scan_result_t r;
      logic         hit;
      r     = '0;
      hit   = 1'b0;
      inputs_seen++;
      dots  = dots + DOT_W'(cycles);
      case (cur_mode)
        MODE_HBLANK: begin
          if (dots >= DOTS_HBLANK) begin
            line = line + 1'b1;
            if (line == FIRST_VBLANK_LINE) begin
              cur_mode     = MODE_VBLANK;
              r.vblank_irq = 1'b1;
              r.frame_done = 1'b1;
              vblank_entries++;
            end else begin
              cur_mode = MODE_OAM;
            end
            dots = dots - DOTS_HBLANK;
          end
        end
        MODE_VBLANK: begin
          if (dots >= DOTS_LINE) begin
            line = line + 1'b1;
            if (line > LAST_LINE) begin
              line     = '0;
              cur_mode = MODE_OAM;
              frame_wraps++;
            end
            dots = dots - DOTS_LINE;
          end
        end
        MODE_OAM: begin
          if (dots >= DOTS_OAM) begin
            dots     = dots - DOTS_OAM;
            cur_mode = MODE_TRANSFER;
          end
        end
        default: begin
          if (dots >= DOTS_TRANSFER) begin
            hit           = (line == line_cmp);
            cur_mode      = MODE_HBLANK;
            dots          = dots - DOTS_TRANSFER;
            r.render_line = 1'b1;
            r.stat_irq    = hblank_int_en || (lyc_int_en && hit);
            match         = hit;
            transfer_ends++;
            if (hit) line_hits++;
            if (r.stat_irq) stat_pulses++;
          end
        end
      endcase
      r.mode        = cur_mode;
      r.scanline    = line;
      r.coincidence = match;
      owed_q.push_back(r);
    endfunction

    function void report(string what, scan_result_t exp_r, scan_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d (%s): exp mode=%0d line=%0d coin=%b vb=%b st=%b rd=%b fd=%b",
                 mismatches, what, exp_r.mode, exp_r.scanline, exp_r.coincidence,
                 exp_r.vblank_irq, exp_r.stat_irq, exp_r.render_line, exp_r.frame_done);
      if (mismatches <= 10)
        $display("             got mode=%0d line=%0d coin=%b vb=%b st=%b rd=%b fd=%b",
                 got.mode, got.scanline, got.coincidence, got.vblank_irq,
                 got.stat_irq, got.render_line, got.frame_done);
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t exp_r;
      string        bad;
      results_seen++;
      if (owed_q.size() == 0) begin
        report("no result owed", '0, got);
        return;
      end
      exp_r = owed_q.pop_front();
      bad   = "";
      if (got.mode        !== exp_r.mode)        bad = {bad, " mode"};
      if (got.scanline    !== exp_r.scanline)    bad = {bad, " scanline"};
      if (got.coincidence !== exp_r.coincidence) bad = {bad, " coincidence"};
      if (got.vblank_irq  !== exp_r.vblank_irq)  bad = {bad, " vblank_irq"};
      if (got.stat_irq    !== exp_r.stat_irq)    bad = {bad, " stat_irq"};
      if (got.render_line !== exp_r.render_line) bad = {bad, " render_line"};
      if (got.frame_done  !== exp_r.frame_done)  bad = {bad, " frame_done"};
      if (bad != "") report({"result", bad}, exp_r, got);
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic [CYCLES_W-1:0]    cpu_cycles = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LINE_W-1:0]      cfg_data  = '0;
  logic                   cfg_ready;
  logic                   in_stall;
  logic                   out_valid;
  logic [1:0]             mode;
  logic [LINE_W-1:0]      scanline;
  logic                   coincidence;
  logic                   vblank_irq;
  logic                   stat_irq;
  logic                   render_line;
  logic                   frame_done;

  // Set while a phase must run with both sides streaming back to back
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  line_timing_scoreboard sb;

  lcd_scanline_mode_timing dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cpu_cycles  (cpu_cycles),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode        (mode),
    .scanline    (scanline),
    .coincidence (coincidence),
    .vblank_irq  (vblank_irq),
    .stat_irq    (stat_irq),
    .render_line (render_line),
    .frame_done  (frame_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the result side at random, with about a 17 percent chance, except in a no-idle stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 17);
    end
  end

  // Watch both channels; every transfer either feeds the model or is checked against it.
  // The values read here are the ones present before this edge, so no race with the drivers.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(cpu_cycles);
      if (out_valid && !out_stall)
        sb.check_result({mode_t'(mode), scanline, coincidence, vblank_irq,
                         stat_irq, render_line, frame_done});
    end
  end

  // Watchdog: end the run when no transfer has happened for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Present one cpu_cycles report and hold it until the block takes it.
  // Valid stays high into the next item unless a one-cycle gap is inserted.
  task automatic send_cycles(input logic [CYCLES_W-1:0] c);
    if (!no_idle && ($urandom_range(0, 99) < 20)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cpu_cycles <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write one register; leave valid high so back-to-back writes need no extra toggle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LINE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Program all three registers, plus the unused index, which the block must ignore
  task automatic program_regs(input logic hb_en, input logic lyc_en,
                              input logic [LINE_W-1:0] cmp);
    write_reg(REG_HBLANK_INT_EN, {7'($urandom_range(0, 127)), hb_en});
    write_reg(REG_LYC_INT_EN, {7'($urandom_range(0, 127)), lyc_en});
    write_reg(REG_LINE_COMPARE, cmp);
    write_reg(2'(REG_LINE_COMPARE + 1), 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // Wait until every owed result has come back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly big steps so the run walks many lines; some small and zero steps too
  task automatic run_phase(input int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      send_cycles(CYCLES_W'($urandom_range(40, 63)));
      else if (pick < 95) send_cycles(CYCLES_W'($urandom_range(0, 63)));
      else                send_cycles('0);
    end
  endtask

  initial begin
    logic [CYCLES_W-1:0] directed_steps [$];
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: both stat causes on line 1 with compare 1, so the pulse must be single.
    // The steps hit zero and full-scale counts, alternating bit patterns,
    // and late transitions whose extra dots carry into the next mode.
    program_regs(1'b1, 1'b1, 8'd1);
    directed_steps = '{6'd0, 6'd63, 6'd63, 6'd63, 6'd63, 6'b101010, 6'b010101, 6'd63,
                       6'd63, 6'd63, 6'd63, 6'd1, 6'd0, 6'd63, 6'd63, 6'd63, 6'd32,
                       6'd16, 6'd8, 6'd4, 6'd2};
    foreach (directed_steps[i]) send_cycles(directed_steps[i]);
    drain();

    // Compare interrupt only, on an early visible line
    program_regs(1'b0, 1'b1, 8'd5);
    run_phase(170);
    drain();

    // Hblank interrupt only, compare out of range; stream with no idling at all
    no_idle = 1'b1;
    program_regs(1'b1, 1'b0, 8'd255);
    run_phase(170);
    drain();
    no_idle = 1'b0;

    // Compare set four lines past the current line, taken modulo 144 so it stays a visible line
    program_regs(1'b0, 1'b1, 8'((sb.line + 8'd4) % 8'd144));
    run_phase(170);
    drain();

    // Last compare line, both enables off
    program_regs(1'b0, 1'b0, LAST_LINE);
    run_phase(170);
    drain();

    repeat (10) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      $display("%0d results never arrived", sb.owed_q.size());
      sb.mismatches++;
    end
    $display("covered %0d cycle reports, %0d results, %0d transfer ends, %0d line matches",
             sb.inputs_seen, sb.results_seen, sb.transfer_ends, sb.line_hits);
    $display("  %0d vblank entries, %0d frame wraps, %0d stat pulses, %0d mismatches",
             sb.vblank_entries, sb.frame_wraps, sb.stat_pulses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
